### hdl/lsfd_pkg.sv
// Shared types, constants and helpers for the LED string frame driver.
`default_nettype none

package lsfd_pkg;

  // Default string length and fixed field widths.
  localparam int PIXEL_COUNT_DEF = 9;
  localparam int PIXEL_COUNT_MAX = 32;
  localparam int LEVEL_W         = 8;
  localparam int WORD_W          = 24;
  localparam int CODE_W          = 3;
  localparam int NUM_W           = 6;
  localparam int PIX_IDX_W       = 5;
  localparam int SHIFT_W         = 4;
  localparam int CFG_ADDR_W      = 1;
  localparam int CFG_DATA_W      = 4;
  localparam int S_TDATA_W       = 40;
  localparam int M_TDATA_W       = 32;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hFF;
  localparam logic [CODE_W-1:0]  CODE_RED   = 3'h4;
  localparam logic [CODE_W-1:0]  CODE_GREEN = 3'h2;
  localparam logic [CODE_W-1:0]  CODE_BLUE  = 3'h1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SUPPRESS   = 1'b1;

  typedef enum logic [1:0] {
    OP_SET_RGB  = 2'd0,
    OP_SET_CODE = 2'd1,
    OP_SET_ONE  = 2'd2,
    OP_ALL_OFF  = 2'd3
  } lsfd_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } lsfd_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic apply;  // take the command on the input and update the store
    logic emit;   // load the output register from the scan index, advance
  } lsfd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
    logic at_last;   // scan index points at the final pixel
    logic suppress;  // refresh suppressed
  } lsfd_stat_t;

  function automatic logic [WORD_W-1:0] code_to_grb(input logic [CODE_W-1:0] code);
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
    r = ((code & CODE_RED)   != '0) ? FULL_LEVEL : '0;
    g = ((code & CODE_GREEN) != '0) ? FULL_LEVEL : '0;
    b = ((code & CODE_BLUE)  != '0) ? FULL_LEVEL : '0;
    return {g, r, b};
  endfunction

  function automatic logic [LEVEL_W-1:0] dim_channel(input logic [LEVEL_W-1:0] level,
                                                      input logic [SHIFT_W-1:0] shift);
    logic [LEVEL_W-1:0] res;
    if (shift >= SHIFT_W'(LEVEL_W)) res = '0;
    else res = level >> shift[2:0];
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/led_string_frame_driver.sv
// Top level of the LED string frame driver.
`default_nettype none

// Keeps PIXEL_COUNT green-red-blue pixels (all off after reset, cleared in the
// reset cycle itself) and takes one command per input transfer: set all to an
// RGB value, set all to a 3-bit colour code, set one pixel (numbered from one;
// numbers outside 1..PIXEL_COUNT change nothing) to a colour code, or all off.
// The command lands in the store in the cycle it is accepted. Unless refresh
// is suppressed the block then streams every pixel in order, one output
// transfer per cycle while the output side does not stall, each channel
// shifted right by the brightness setting, with tlast on the final pixel. A
// command keeps the input busy until the final pixel of its refresh has been
// loaded for output, each pixel read from the single store read index; with
// refresh suppressed the block stays ready for the next command. Write
// configuration only while no refresh is in flight.
module led_string_frame_driver import lsfd_pkg::*; #(
  parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // red_level[7:0], green_level[15:8], blue_level[23:16], colour_code[26:24],
  // pixel_number[32:27], zero pad[39:33]
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // pixel_index[4:0], grb_word[28:5], zero pad[31:29]
  output logic [M_TDATA_W-1:0]       m_tdata,
  // last_pixel
  output logic                       m_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  lsfd_cmd_t            cmd;
  lsfd_stat_t           stat;
  logic [PIX_IDX_W-1:0] out_index;
  logic [WORD_W-1:0]    out_word;

  // Sequence accept and refresh.
  lsfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the store and the output register.
  lsfd_datapath #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .opcode       (s_tuser),
    .red_level    (s_tdata[7:0]),
    .green_level  (s_tdata[15:8]),
    .blue_level   (s_tdata[23:16]),
    .colour_code  (s_tdata[26:24]),
    .pixel_number (s_tdata[32:27]),
    .m_tready     (m_tready),
    .out_valid    (m_tvalid),
    .out_index    (out_index),
    .out_word     (out_word),
    .out_last     (m_tlast)
  );

  assign m_tdata = {3'b000, out_word, out_index};

  // A command is never taken while the store is being scanned.
  a_no_apply_during_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.apply && cmd.emit))
    else $error("command applied during a refresh scan");

  // Emitting the final pixel hands control back to command acceptance.
  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.at_last) |=> s_tready)
    else $error("block not ready after the final pixel");

  // An unsuppressed command blocks the input for the refresh that follows.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && !stat.suppress) |=> !s_tready)
    else $error("input ready right after starting a refresh");

  // The flagged word is always the final pixel of the string.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[4:0] == PIX_IDX_W'(PIXEL_COUNT - 1)))
    else $error("tlast on a pixel other than the final one");

endmodule

`default_nettype wire

### hdl/lsfd_ctrl.sv
// Controller state machine: command acceptance and refresh sequencing.
`default_nettype none

module lsfd_ctrl import lsfd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire lsfd_stat_t stat,
  output lsfd_cmd_t       cmd
);

  lsfd_state_t state;
  lsfd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.apply = 1'b1;
          if (!stat.suppress) state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.at_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/lsfd_datapath.sv
// Datapath: pixel store, config registers, dimming and output register.
`default_nettype none

module lsfd_datapath import lsfd_pkg::*; #(
  parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lsfd_cmd_t             cmd,
  output lsfd_stat_t                 stat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [1:0]            opcode,
  input  wire logic [LEVEL_W-1:0]    red_level,
  input  wire logic [LEVEL_W-1:0]    green_level,
  input  wire logic [LEVEL_W-1:0]    blue_level,
  input  wire logic [CODE_W-1:0]     colour_code,
  input  wire logic [NUM_W-1:0]      pixel_number,
  input  wire logic                  m_tready,
  output logic                       out_valid,
  output logic [PIX_IDX_W-1:0]       out_index,
  output logic [WORD_W-1:0]          out_word,
  output logic                       out_last
);

  localparam int IDX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

  logic [WORD_W-1:0]  store [PIXEL_COUNT];
  logic [IDX_W-1:0]   idx;
  logic [SHIFT_W-1:0] brightness_shift;
  logic               refresh_suppress;

  logic               fill_en;
  logic [WORD_W-1:0]  fill_word;
  logic               one_en;
  logic [WORD_W-1:0]  code_word;
  logic [WORD_W-1:0]  rd_word;

  // Decode the command into a whole-store fill or a single-entry write.
  always_comb begin
    fill_en   = 1'b0;
    one_en    = 1'b0;
    fill_word = '0;
    code_word = code_to_grb(colour_code);
    case (lsfd_op_t'(opcode))
      OP_SET_RGB: begin
        fill_en   = 1'b1;
        fill_word = {green_level, red_level, blue_level};
      end
      OP_SET_CODE: begin
        fill_en   = 1'b1;
        fill_word = code_word;
      end
      OP_SET_ONE: one_en = 1'b1;
      OP_ALL_OFF: fill_en = 1'b1;
      default: fill_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIXEL_COUNT; i++) store[i] <= '0;
    end else if (cmd.apply) begin
      for (int i = 0; i < PIXEL_COUNT; i++) begin
        if (fill_en) store[i] <= fill_word;
        else if (one_en && pixel_number == NUM_W'(i + 1)) store[i] <= code_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_shift <= '0;
      refresh_suppress <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_BRIGHTNESS) brightness_shift <= cfg_data;
      if (cfg_addr == CFG_SUPPRESS)   refresh_suppress <= cfg_data[0];
    end
  end

  // Scan index: restart on a new command, advance on each emitted word.
  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (cmd.apply) idx <= '0;
    else if (cmd.emit) idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
  end

  assign rd_word = store[idx];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (m_tready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index <= PIX_IDX_W'(idx);
      out_word  <= {dim_channel(rd_word[23:16], brightness_shift),
                    dim_channel(rd_word[15:8],  brightness_shift),
                    dim_channel(rd_word[7:0],   brightness_shift)};
      out_last  <= (idx == LAST_IDX);
    end
  end

  assign stat.out_free = !out_valid || m_tready;
  assign stat.at_last  = (idx == LAST_IDX);
  assign stat.suppress = refresh_suppress;

endmodule

`default_nettype wire
